FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/psfp_pkg.sv
`default_nettype none

package psfp_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CMD_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH    = 2'd2;

   localparam logic [POS_W-1:0] FRAME_LENGTH_RESET = 6'd50;

   typedef enum logic [1:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_DATA,
      PH_SUM
   } phase_type;

   typedef struct packed {
      logic              en;
      logic [POS_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
   } store_rd_type;

   // Source position for each output position: pair swaps and the 46..49 reversal.
   function automatic logic [POS_W-1:0] source_of(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] src;
      unique case (pos)
         6'd3, 6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd17,
         6'd19, 6'd22, 6'd24, 6'd28: src = pos + 6'd1;
         6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18,
         6'd20, 6'd23, 6'd25, 6'd29: src = pos - 6'd1;
         6'd46:   src = 6'd49;
         6'd47:   src = 6'd48;
         6'd48:   src = 6'd47;
         6'd49:   src = 6'd46;
         default: src = pos;
      endcase
      return src;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/psfp_if.sv
`default_nettype none

interface psfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [5:0] byte_index;
   logic       last;

   modport source (output valid, output frame_byte, output byte_index, output last,
                   input ready);
   modport sink   (input valid, input frame_byte, input byte_index, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psfp_store.sv
`default_nettype none

module psfp_store #(
   parameter int BUFFER_BYTES = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  psfp_pkg::store_wr_type         wr,
   input  psfp_pkg::store_rd_type         rd,
   output logic [psfp_pkg::BYTE_W-1:0]    rd_byte
);
   import psfp_pkg::*;

   localparam int AW    = $clog2(BUFFER_BYTES);
   localparam int CMP_W = $clog2(BUFFER_BYTES + 1) + 1;

   logic [BYTE_W-1:0]       store_mem [BUFFER_BYTES];
   logic [BUFFER_BYTES-1:0] valid_ff;
   logic [BYTE_W-1:0]       mem_q_ff;
   logic                    hit_ff;
   logic                    wr_in_range;
   logic                    rd_in_range;
   logic [AW-1:0]           wr_idx;
   logic [AW-1:0]           rd_idx;
   logic                    hit_in;

   always_comb begin
      wr_idx      = AW'(wr.addr);
      rd_idx      = AW'(rd.addr);
      wr_in_range = CMP_W'(wr.addr) < CMP_W'(BUFFER_BYTES);
      rd_in_range = CMP_W'(rd.addr) < CMP_W'(BUFFER_BYTES);
      hit_in      = rd_in_range && valid_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         store_mem[wr_idx] <= wr.data;
      end
      if (rd.en) begin
         mem_q_ff <= store_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr_in_range) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         hit_ff <= hit_in;
      end
   end

   // never-written and out-of-buffer positions read as zero
   assign rd_byte = hit_ff ? mem_q_ff : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/psfp_cmd_queue.sv
`default_nettype none

module psfp_cmd_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire  [psfp_pkg::POS_W-1:0]   push_len,
   input  wire                          pop,
   output logic [psfp_pkg::POS_W-1:0]   pop_len,
   output logic                         empty,
   output logic                         full
);
   import psfp_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   logic [POS_W-1:0] entry_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(CMD_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_len = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/psfp_front.sv
`default_nettype none

module psfp_front #(
   parameter int BUFFER_BYTES = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   psfp_req_if.sink                            req_chan,
   input  wire                                 csr_we,
   input  wire  [psfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [psfp_pkg::BYTE_W-1:0]         csr_wdata,
   input  wire                                 hold,
   output psfp_pkg::store_wr_type              wr,
   output logic                                push,
   output logic [psfp_pkg::POS_W-1:0]          push_len
);
   import psfp_pkg::*;

   localparam int CMP_W = $clog2(BUFFER_BYTES + 1) + 1;

   logic [BYTE_W-1:0] pre_first_ff;
   logic [BYTE_W-1:0] pre_second_ff;
   logic [POS_W-1:0]  frame_len_ff;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [POS_W-1:0]  wp_ff;
   logic [POS_W-1:0]  wp_in;
   logic [BYTE_W-1:0] sum_ff;
   logic [BYTE_W-1:0] sum_in;

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic [POS_W-1:0]  wp_next;
   logic              overflow;
   logic              data_done;

   assign req_chan.ready = !hold;
   assign accept         = req_chan.valid && !hold;
   assign b              = req_chan.rx_byte;
   assign push_len       = frame_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_first_ff  <= '0;
         pre_second_ff <= '0;
         frame_len_ff  <= FRAME_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PREAMBLE_FIRST:  pre_first_ff  <= csr_wdata;
            CSR_PREAMBLE_SECOND: pre_second_ff <= csr_wdata;
            CSR_FRAME_LENGTH:    frame_len_ff  <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         wp_ff    <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         wp_ff    <= wp_in;
         sum_ff   <= sum_in;
      end
   end

   always_comb begin
      wp_next   = wp_ff + 6'd1;
      overflow  = CMP_W'(wp_ff) >= CMP_W'(BUFFER_BYTES - 1);
      data_done = (frame_len_ff == '0) ||
                  ({1'b0, wp_next} >= ({1'b0, frame_len_ff} - 7'd1));

      phase_in = phase_ff;
      wp_in    = wp_ff;
      sum_in   = sum_ff;
      wr       = '0;
      push     = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               wp_in   = '0;
               sum_in  = '0;
               wr.en   = 1'b1;
               wr.addr = '0;
               wr.data = b;
               if (b == pre_first_ff) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               if (b == pre_second_ff) begin
                  wp_in    = 6'd2;
                  wr.en    = 1'b1;
                  wr.addr  = 6'd1;
                  wr.data  = b;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_DATA: begin
               if (overflow) begin
                  phase_in = PH_HUNT1;
               end else begin
                  wr.en   = 1'b1;
                  wr.addr = wp_ff;
                  wr.data = b;
                  wp_in   = wp_next;
                  sum_in  = sum_ff + b;
                  if (data_done) begin
                     phase_in = PH_SUM;
                  end
               end
            end
            PH_SUM: begin
               wr.en    = 1'b1;
               wr.addr  = wp_ff;
               wr.data  = b;
               push     = (sum_ff == b) && (frame_len_ff != '0);
               phase_in = PH_HUNT1;
            end
            default: phase_in = PH_HUNT1;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/psfp_back.sv
`default_nettype none

module psfp_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              q_empty,
   input  wire  [psfp_pkg::POS_W-1:0]       q_len,
   output logic                             q_pop,
   output psfp_pkg::store_rd_type           rd,
   input  wire  [psfp_pkg::BYTE_W-1:0]      rd_byte,
   output logic                             busy,
   psfp_rsp_if.source                       rsp_chan
);
   import psfp_pkg::*;

   logic             active_ff;
   logic [POS_W-1:0] len_ff;
   logic [POS_W-1:0] count_ff;
   logic             out_valid_ff;
   logic [POS_W-1:0] idx_ff;
   logic             last_ff;
   logic             issue;
   logic             is_last;

   assign busy    = active_ff;
   assign q_pop   = !active_ff && !q_empty;
   assign issue   = active_ff && (!out_valid_ff || rsp_chan.ready);
   assign is_last = (count_ff == len_ff - 6'd1);
   assign rd.en   = issue;
   assign rd.addr = source_of(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            active_ff <= 1'b1;
         end else if (issue && is_last) begin
            active_ff <= 1'b0;
         end
         if (issue) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         len_ff   <= q_len;
         count_ff <= '0;
      end else if (issue) begin
         count_ff <= count_ff + 6'd1;
      end
      if (issue) begin
         idx_ff  <= count_ff;
         last_ff <= is_last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = rd_byte;
   assign rsp_chan.byte_index = idx_ff;
   assign rsp_chan.last       = last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/preamble_sum_frame_parser.sv
// After its checksum byte is taken, a matched frame's first byte passes the command queue,
// the emitter's active flag and the registered store read. Throughput: one rx byte per cycle
// while hunting and collecting; after a checksum match input ready stays low while the emitter
// reads the frame store, one store read port, one byte per cycle while the output is ready.
// Reset (synchronous, active high): hunting, registers at 0/0/50, frame store reads as zero.
`default_nettype none

module preamble_sum_frame_parser #(
   parameter int BUFFER_BYTES = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   psfp_req_if.sink                          req_chan,
   psfp_rsp_if.source                        rsp_chan,
   input  wire                               csr_we,
   input  wire  [psfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [psfp_pkg::BYTE_W-1:0]       csr_wdata
);
   import psfp_pkg::*;
   `include "assert_macros.svh"

   store_wr_type      wr;
   store_rd_type      rd;
   logic [BYTE_W-1:0] rd_byte;
   logic              push;
   logic [POS_W-1:0]  push_len;
   logic              q_pop;
   logic [POS_W-1:0]  q_len;
   logic              q_empty;
   logic              q_full;
   logic              back_busy;
   logic              hold;

   assign hold = !q_empty || q_full || back_busy;

   psfp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .hold      (hold),
      .wr        (wr),
      .push      (push),
      .push_len  (push_len)
   );

   psfp_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_len (push_len),
      .pop      (q_pop),
      .pop_len  (q_len),
      .empty    (q_empty),
      .full     (q_full)
   );

   psfp_store #(.BUFFER_BYTES(BUFFER_BYTES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_byte (rd_byte)
   );

   psfp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_len    (q_len),
      .q_pop    (q_pop),
      .rd       (rd),
      .rd_byte  (rd_byte),
      .busy     (back_busy),
      .rsp_chan (rsp_chan)
   );

   `ASSERT_IMPL(a_no_write_while_emit, clock, reset, back_busy, !wr.en)
   `ASSERT_IMPL(a_push_has_room, clock, reset, push, !q_full)
   `ASSERT_NEXT(a_hold_after_match, clock, reset, push, !req_chan.ready)
   `ASSERT_IMPL(a_read_only_when_busy, clock, reset, rd.en, back_busy)

endmodule

`default_nettype wire

FILE: tb/psfp_frame_checker.sv
module psfp_frame_checker (
   input  wire                            clock,
   input  wire                            reset,
   psfp_req_if                            req_chan,
   psfp_rsp_if                            rsp_chan,
   input  wire                            csr_we,
   input  wire  [psfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [psfp_pkg::BYTE_W-1:0]    csr_wdata,
   output int                             error_count,
   output int                             bytes_pending,
   output int                             frames_matched,
   output int                             bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import psfp_pkg::*;

   localparam int STORE_DEPTH = 64;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [POS_W-1:0]  byte_index;
      logic              last;
   } frame_byte_type;

   frame_byte_type    expected_bytes[$];
   frame_byte_type    want;
   phase_type         parse_state;
   int                wr_pos;
   logic [BYTE_W-1:0] running_sum;
   logic [BYTE_W-1:0] rx_store [STORE_DEPTH];
   logic [BYTE_W-1:0] cfg_first;
   logic [BYTE_W-1:0] cfg_second;
   logic [POS_W-1:0]  cfg_len;

   // pair swaps 3/4..19/20, 22/23, 24/25, 28/29; 46..49 reversed
   function automatic int swap_source(input int pos);
      if (pos >= 3 && pos <= 20) return (pos % 2) ? pos + 1 : pos - 1;
      if (pos >= 22 && pos <= 25) return (pos % 2) ? pos - 1 : pos + 1;
      if (pos == 28 || pos == 29) return 57 - pos;
      if (pos >= 46 && pos <= 49) return 95 - pos;
      return pos;
   endfunction

   task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
      frame_byte_type e;
      int             i;
      case (parse_state)
         PH_HUNT1: begin
            wr_pos      = 0;
            running_sum = '0;
            rx_store[0] = b;
            if (b == cfg_first) parse_state = PH_HUNT2;
         end
         PH_HUNT2: begin
            if (b == cfg_second) begin
               wr_pos      = 2;
               rx_store[1] = b;
               parse_state = PH_DATA;
            end else begin
               parse_state = PH_HUNT1;
            end
         end
         PH_DATA: begin
            if (wr_pos >= STORE_DEPTH - 1) begin
               parse_state = PH_HUNT1;
            end else begin
               rx_store[wr_pos] = b;
               wr_pos           = wr_pos + 1;
               running_sum      = running_sum + b;
               if (wr_pos >= int'(cfg_len) - 1) parse_state = PH_SUM;
            end
         end
         PH_SUM: begin
            rx_store[wr_pos] = b;
            if (running_sum == b) begin
               frames_matched++;
               for (i = 0; i < int'(cfg_len); i++) begin
                  e.frame_byte = rx_store[swap_source(i)];
                  e.byte_index = i[POS_W-1:0];
                  e.last       = (i == int'(cfg_len) - 1);
                  expected_bytes.push_back(e);
               end
            end
            parse_state = PH_HUNT1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         parse_state = PH_HUNT1;
         wr_pos      = 0;
         running_sum = '0;
         cfg_first   = '0;
         cfg_second  = '0;
         cfg_len     = FRAME_LENGTH_RESET;
         foreach (rx_store[i]) rx_store[i] = '0;
         expected_bytes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PREAMBLE_FIRST:  cfg_first  = csr_wdata;
               CSR_PREAMBLE_SECOND: cfg_second = csr_wdata;
               CSR_FRAME_LENGTH:    cfg_len    = csr_wdata[POS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_bytes.size() == 0) begin
               error_count++;
               $error("unexpected frame byte 0x%02h at index %0d",
                      rsp_chan.frame_byte, rsp_chan.byte_index);
            end else begin
               want = expected_bytes.pop_front();
               bytes_checked++;
               if (rsp_chan.frame_byte !== want.frame_byte) begin
                  error_count++;
                  $error("frame_byte: expected 0x%02h, got 0x%02h",
                         want.frame_byte, rsp_chan.frame_byte);
               end
               if (rsp_chan.byte_index !== want.byte_index) begin
                  error_count++;
                  $error("byte_index: expected %0d, got %0d",
                         want.byte_index, rsp_chan.byte_index);
               end
               if (rsp_chan.last !== want.last) begin
                  error_count++;
                  $error("last: expected %0b, got %0b", want.last, rsp_chan.last);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) take_rx_byte(req_chan.rx_byte);
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

FILE: tb/preamble_sum_frame_parser_tb.sv
module preamble_sum_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psfp_pkg::*;

   localparam int DRAIN_CYCLES = 70;
   localparam int LONG_HOLD    = 300;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   int error_count;
   int bytes_pending;
   int frames_matched;
   int bytes_checked;

   logic [BYTE_W-1:0] cur_first;
   logic [BYTE_W-1:0] cur_second;
   logic [POS_W-1:0]  cur_len;
   int                sender_idle_pct = 0;
   int                rsp_stall_pct   = 0;
   int                items_sent      = 0;
   int                hold_requests   = 0;
   int                hold_served     = 0;
   int                hold_left       = 0;
   int                len_plan [8]    = '{63, 6, 4, 0, 50, 0, 63, 0};
   int                idle_plan [4]   = '{0, 73, 0, 14};
   int                stall_plan [4]  = '{0, 0, 73, 14};

   psfp_req_if req_chan ();
   psfp_rsp_if rsp_chan ();

   preamble_sum_frame_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   psfp_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .bytes_pending  (bytes_pending),
      .frames_matched (frames_matched),
      .bytes_checked  (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("preamble_sum_frame_parser_tb: done, errors");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_chan.ready <= 1'b0;
         hold_served    <= hold_requests;
         hold_left      <= LONG_HOLD;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PREAMBLE_FIRST:  cur_first  = val;
         CSR_PREAMBLE_SECOND: cur_second = val;
         CSR_FRAME_LENGTH:    cur_len    = val[POS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_frame(input bit good_sum);
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] total;
      int                n;
      total = '0;
      send_byte(cur_first);
      send_byte(cur_second);
      for (n = 2; n < int'(cur_len) - 1; n++) begin
         b     = BYTE_W'($urandom_range(0, 255));
         total = total + b;
         send_byte(b);
      end
      if (!good_sum) total = total + BYTE_W'($urandom_range(1, 255));
      send_byte(total);
   endtask

   // mostly well-formed frames; bad sums, noise and broken preambles mixed in
   task automatic run_segment(input int budget);
      int stop_at;
      int pick;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_frame(1'b1);
         end else if (pick < 78) begin
            send_frame(1'b0);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
         end else begin
            send_byte(cur_first);
            send_byte(cur_second ^ BYTE_W'($urandom_range(1, 255)));
         end
      end
   endtask

   initial begin
      int ph;
      int k;
      int seg_len;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      cur_first        = '0;
      cur_second       = '0;
      cur_len          = FRAME_LENGTH_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_PREAMBLE_FIRST, 8'hFF);
      write_reg(CSR_PREAMBLE_SECOND, 8'h00);
      write_reg(CSR_FRAME_LENGTH, 8'd4);
      // noise, then a repeated first byte where the second is due
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // shortest frame; swap at position 3 reads a never-written byte
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // bad checksum, dropped; then a good frame
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h81);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'h7F);
      // frame length shortened while a frame is open
      write_reg(CSR_FRAME_LENGTH, 8'd63);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      write_reg(CSR_FRAME_LENGTH, 8'd6);
      send_byte(8'h04);
      send_byte(8'h0A);

      for (ph = 0; ph < 4; ph++) begin
         sender_idle_pct = idle_plan[ph];
         rsp_stall_pct   = stall_plan[ph];
         for (k = 0; k < 2; k++) begin
            seg_len = len_plan[ph * 2 + k];
            if (seg_len == 0) seg_len = $urandom_range(4, 20);
            write_reg(CSR_PREAMBLE_FIRST, BYTE_W'($urandom_range(0, 255)));
            write_reg(CSR_PREAMBLE_SECOND, BYTE_W'($urandom_range(0, 255)));
            write_reg(CSR_FRAME_LENGTH, BYTE_W'(seg_len));
            if (ph == 0 && k == 1) hold_requests++;
            run_segment(20);
         end
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d rx bytes across 8 register settings and 4 idle/stall mixes,",
               items_sent);
      $display("with %0d frames matched and %0d frame bytes compared.",
               frames_matched, bytes_checked);
      if (error_count == 0) begin
         $display("preamble_sum_frame_parser_tb: done, clean");
      end else begin
         $display("preamble_sum_frame_parser_tb: done, errors");
      end
      $finish;
   end

endmodule
